// File: hdl/hcbd_pkg.sv
// Shared types, character codes and limits for the chunked body decoder.
// Depends on nothing; the decoder module takes names from here by scope.
package hcbd_pkg;

    localparam int SIZE_BITS      = 24;
    localparam int MAX_BODY_BYTES = 131072;
    localparam int COUNT_W        = 17;

    localparam logic [SIZE_BITS-1:0] SIZE_MAX = {SIZE_BITS{1'b1}};
    // Shifting in one more digit above this value overflows the size register.
    localparam logic [SIZE_BITS-1:0] SIZE_SAT_LIMIT = SIZE_MAX >> 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX =
        ((MAX_BODY_BYTES - 1) < ((1 << COUNT_W) - 1)) ?
        COUNT_W'(MAX_BODY_BYTES - 1) : {COUNT_W{1'b1}};

    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UF   = 8'h46;

    typedef enum logic [1:0] {
        REASON_ZERO_SIZE = 2'd0,
        REASON_BAD_CHAR  = 2'd1,
        REASON_RAN_OUT   = 2'd2
    } reason_t;

    typedef enum logic [6:0] {
        PH_SIZE     = 7'b0000001,
        PH_SIZE_CR  = 7'b0000010,
        PH_EXT      = 7'b0000100,
        PH_DATA     = 7'b0001000,
        PH_TRAIL    = 7'b0010000,
        PH_TRAIL_LF = 7'b0100000,
        PH_DONE     = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] b);
        hex_t h;
        logic [7:0] d;
        h = '{ok: 1'b0, value: 4'd0};
        d = 8'd0;
        if (b >= CH_0 && b <= CH_9) begin
            d = b - CH_0;
            h = '{ok: 1'b1, value: d[3:0]};
        end
        else if (b >= CH_LA && b <= CH_LF_HEX) begin
            d = b - CH_LA + 8'd10;
            h = '{ok: 1'b1, value: d[3:0]};
        end
        else if (b >= CH_UA && b <= CH_UF) begin
            d = b - CH_UA + 8'd10;
            h = '{ok: 1'b1, value: d[3:0]};
        end
        return h;
    endfunction

endpackage

// File: hdl/http_chunked_body_decoder.sv
// HTTP/1.1 chunked body decoder: input word register, byte-wide parser, result register.
// Depends on hcbd_pkg for phase codes, character codes and limits.
//
// Takes one raw body byte per word and passes on payload bytes only; the word
// flagged last_byte also yields a result carrying the decoded length and the
// end reason, after which the parser rearms for the next body. One word per
// cycle sustained while the output is not stalled: while a word sits in the
// input register the parser handles it, and the result register is written
// as the word advances. The result register is refilled in the same cycle it
// is taken, and words that produce no result advance without touching it. A
// held result that is stalled also holds the input register, so the input
// stalls once both registers are full.
module http_chunked_body_decoder (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   in_byte,
    input  logic                         last_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [7:0]                   data_byte,
    output logic                         data_valid,
    output logic                         body_end,
    output logic [hcbd_pkg::COUNT_W-1:0] decoded_length,
    output logic [1:0]                   end_reason
);

    // input word register
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // parser state
    hcbd_pkg::phase_t                phase_reg, phase_next;
    logic [hcbd_pkg::SIZE_BITS-1:0]  rem_reg, rem_next;
    logic [hcbd_pkg::COUNT_W-1:0]    cnt_reg, cnt_next;
    hcbd_pkg::reason_t               rsn_reg, rsn_next;

    // result register
    logic                            out_vld_reg;
    logic [7:0]                      data_byte_reg;
    logic                            data_valid_reg;
    logic                            body_end_reg;
    logic [hcbd_pkg::COUNT_W-1:0]    len_reg;
    logic [1:0]                      reason_reg;

    logic                            advance;
    logic                            emit;
    logic                            do_size;
    logic                            do_pay;
    logic                            has_result;
    logic [hcbd_pkg::SIZE_BITS-1:0]  rem_dec;
    hcbd_pkg::hex_t                  hex;

    assign advance    = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall   = in_vld_reg && !advance;
    assign has_result = emit || in_last_reg;
    assign hex        = hcbd_pkg::hex_decode(in_byte_reg);
    assign rem_dec    = rem_reg - hcbd_pkg::SIZE_BITS'(rem_reg != '0);

    always_comb
    begin
        phase_next = phase_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        rsn_next   = rsn_reg;
        emit       = 1'b0;
        do_size    = 1'b0;
        do_pay     = 1'b0;

        unique case (phase_reg)
            hcbd_pkg::PH_SIZE:
            begin
                do_size = 1'b1;
            end
            hcbd_pkg::PH_SIZE_CR:
            begin
                phase_next = hcbd_pkg::PH_DATA;
                do_pay     = (in_byte_reg != hcbd_pkg::CH_LF);
            end
            hcbd_pkg::PH_EXT:
            begin
                if (in_byte_reg == hcbd_pkg::CH_LF)
                    phase_next = hcbd_pkg::PH_DATA;
            end
            hcbd_pkg::PH_DATA:
            begin
                do_pay = 1'b1;
            end
            hcbd_pkg::PH_TRAIL:
            begin
                if (in_byte_reg == hcbd_pkg::CH_CR)
                    phase_next = hcbd_pkg::PH_TRAIL_LF;
                else
                begin
                    phase_next = hcbd_pkg::PH_SIZE;
                    do_size    = (in_byte_reg != hcbd_pkg::CH_LF);
                end
            end
            hcbd_pkg::PH_TRAIL_LF:
            begin
                phase_next = hcbd_pkg::PH_SIZE;
                do_size    = (in_byte_reg != hcbd_pkg::CH_LF);
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        if (do_size)
        begin
            if (in_byte_reg == hcbd_pkg::CH_CR || in_byte_reg == hcbd_pkg::CH_LF ||
                in_byte_reg == hcbd_pkg::CH_SEMI)
            begin
                if (rem_reg == '0)
                begin
                    rsn_next   = hcbd_pkg::REASON_ZERO_SIZE;
                    phase_next = hcbd_pkg::PH_DONE;
                end
                else if (in_byte_reg == hcbd_pkg::CH_CR)
                    phase_next = hcbd_pkg::PH_SIZE_CR;
                else if (in_byte_reg == hcbd_pkg::CH_LF)
                    phase_next = hcbd_pkg::PH_DATA;
                else
                    phase_next = hcbd_pkg::PH_EXT;
            end
            else if (!hex.ok)
            begin
                rsn_next   = hcbd_pkg::REASON_BAD_CHAR;
                phase_next = hcbd_pkg::PH_DONE;
            end
            else if (rem_reg > hcbd_pkg::SIZE_SAT_LIMIT)
                rem_next = hcbd_pkg::SIZE_MAX;
            else
                rem_next = {rem_reg[hcbd_pkg::SIZE_BITS-5:0], hex.value};
        end

        if (do_pay)
        begin
            emit     = 1'b1;
            rem_next = rem_dec;
            if (cnt_reg < hcbd_pkg::COUNT_MAX)
                cnt_next = cnt_reg + 1'b1;
            if (rem_dec == '0)
                phase_next = hcbd_pkg::PH_TRAIL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_valid && !in_stall)
            in_vld_reg <= 1'b1;
        else if (advance)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= in_byte;
            in_last_reg <= last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= hcbd_pkg::PH_SIZE;
            rem_reg   <= '0;
            cnt_reg   <= '0;
            rsn_reg   <= hcbd_pkg::REASON_RAN_OUT;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                // rearm for the next body
                phase_reg <= hcbd_pkg::PH_SIZE;
                rem_reg   <= '0;
                cnt_reg   <= '0;
                rsn_reg   <= hcbd_pkg::REASON_RAN_OUT;
            end
            else
            begin
                phase_reg <= phase_next;
                rem_reg   <= rem_next;
                cnt_reg   <= cnt_next;
                rsn_reg   <= rsn_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= has_result;
        else if (!out_stall)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            data_byte_reg  <= emit ? in_byte_reg : 8'd0;
            data_valid_reg <= emit;
            body_end_reg   <= in_last_reg;
            len_reg        <= in_last_reg ? cnt_next : '0;
            reason_reg     <= in_last_reg ? rsn_next : hcbd_pkg::REASON_ZERO_SIZE;
        end
    end

    assign out_valid      = out_vld_reg;
    assign data_byte      = data_byte_reg;
    assign data_valid     = data_valid_reg;
    assign body_end       = body_end_reg;
    assign decoded_length = len_reg;
    assign end_reason     = reason_reg;

`ifndef ASSERT_OFF
    a_result_has_content: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (data_valid_reg || body_end_reg))
        else $error("result word carries neither payload nor end of body");

    a_done_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && phase_reg == hcbd_pkg::PH_DONE) |-> !emit)
        else $error("payload emitted after decoding stopped");

    a_held_word_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !advance) |=> (in_vld_reg && $stable(in_byte_reg)))
        else $error("input word lost while waiting for result slot");

    a_last_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=>
        (phase_reg == hcbd_pkg::PH_SIZE && cnt_reg == '0 && rem_reg == '0))
        else $error("parser did not rearm after end of body");
`endif

endmodule

// File: verif/http_chunked_body_decoder_test.sv
// Self-checking testbench for the chunked body decoder: directed and random bodies.
// Depends on hcbd_pkg for phase codes, character codes, reasons and size limits.
`timescale 1ns / 100ps
module http_chunked_body_decoder_test;

    localparam int RANDOM_ITEMS = 1250;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int CALM_TAIL    = 150;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       drain;
    } body_item_t;

    typedef struct packed {
        logic [7:0]                   data;
        logic                         valid;
        logic                         last;
        logic [hcbd_pkg::COUNT_W-1:0] len;
        logic [1:0]                   reason;
    } decoded_word_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [7:0]                   in_byte = 8'd0;
    logic                         last_byte = 1'b0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [7:0]                   data_byte;
    logic                         data_valid;
    logic                         body_end;
    logic [hcbd_pkg::COUNT_W-1:0] decoded_length;
    logic [1:0]                   end_reason;

    http_chunked_body_decoder u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_byte        (in_byte),
        .last_byte      (last_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .data_byte      (data_byte),
        .data_valid     (data_valid),
        .body_end       (body_end),
        .decoded_length (decoded_length),
        .end_reason     (end_reason)
    );

    always #10 clk = ~clk;

    // Stimulus and expected words
    body_item_t    body_items[$];
    logic [7:0]    body_bytes[$];
    decoded_word_t expected_words[$];
    logic          drain_next = 1'b0;
    int            random_items = 0;
    int            calm_from = 0;
    longint        cycle_limit = 64'd100000000;
    longint        cycle_cnt = 0;

    // Decoder prediction state
    hcbd_pkg::phase_t               dec_phase = hcbd_pkg::PH_SIZE;
    logic [hcbd_pkg::SIZE_BITS-1:0] size_acc = '0;
    logic [hcbd_pkg::COUNT_W-1:0]   pred_len = '0;
    hcbd_pkg::reason_t              body_reason = hcbd_pkg::REASON_RAN_OUT;
    logic                           out_hit;
    logic [7:0]                     out_val;

    int fed_cnt = 0;
    int due_cnt = 0;
    int got_cnt = 0;
    int mismatches = 0;
    int bodies = 0;
    int payload_words = 0;
    int reason_hits[3] = '{0, 0, 0};

    function automatic int nibble_of(input logic [7:0] b);
        if (b >= "0" && b <= "9")
            return int'(b) - int'("0");
        if (b >= "a" && b <= "f")
            return int'(b) - int'("a") + 10;
        if (b >= "A" && b <= "F")
            return int'(b) - int'("A") + 10;
        return -1;
    endfunction

    task automatic take_size_char(input logic [7:0] b);
        int hv;
        hv = nibble_of(b);
        if (b == hcbd_pkg::CH_CR || b == hcbd_pkg::CH_LF || b == hcbd_pkg::CH_SEMI) begin
            if (size_acc == '0) begin
                body_reason = hcbd_pkg::REASON_ZERO_SIZE;
                dec_phase   = hcbd_pkg::PH_DONE;
            end
            else if (b == hcbd_pkg::CH_CR)
                dec_phase = hcbd_pkg::PH_SIZE_CR;
            else if (b == hcbd_pkg::CH_LF)
                dec_phase = hcbd_pkg::PH_DATA;
            else
                dec_phase = hcbd_pkg::PH_EXT;
        end
        else if (hv < 0) begin
            body_reason = hcbd_pkg::REASON_BAD_CHAR;
            dec_phase   = hcbd_pkg::PH_DONE;
        end
        else if (size_acc > hcbd_pkg::SIZE_SAT_LIMIT)
            size_acc = hcbd_pkg::SIZE_MAX;
        else
            size_acc = {size_acc[hcbd_pkg::SIZE_BITS-5:0], 4'(hv)};
    endtask

    task automatic pass_payload(input logic [7:0] b);
        out_hit = 1'b1;
        out_val = b;
        if (pred_len < hcbd_pkg::COUNT_MAX)
            pred_len = pred_len + 1'b1;
        if (size_acc != '0)
            size_acc = size_acc - 1'b1;
        if (size_acc == '0)
            dec_phase = hcbd_pkg::PH_TRAIL;
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic last);
        decoded_word_t w;
        out_hit = 1'b0;
        out_val = 8'd0;
        case (dec_phase)
            hcbd_pkg::PH_SIZE: take_size_char(b);
            hcbd_pkg::PH_SIZE_CR:
            begin
                dec_phase = hcbd_pkg::PH_DATA;
                if (b != hcbd_pkg::CH_LF)
                    pass_payload(b);
            end
            hcbd_pkg::PH_EXT:
            begin
                if (b == hcbd_pkg::CH_LF)
                    dec_phase = hcbd_pkg::PH_DATA;
            end
            hcbd_pkg::PH_DATA: pass_payload(b);
            hcbd_pkg::PH_TRAIL:
            begin
                if (b == hcbd_pkg::CH_CR)
                    dec_phase = hcbd_pkg::PH_TRAIL_LF;
                else if (b == hcbd_pkg::CH_LF)
                    dec_phase = hcbd_pkg::PH_SIZE;
                else
                begin
                    dec_phase = hcbd_pkg::PH_SIZE;
                    take_size_char(b);
                end
            end
            hcbd_pkg::PH_TRAIL_LF:
            begin
                dec_phase = hcbd_pkg::PH_SIZE;
                if (b != hcbd_pkg::CH_LF)
                    take_size_char(b);
            end
            default: ;
        endcase
        if (out_hit || last) begin
            w.data   = out_val;
            w.valid  = out_hit;
            w.last   = last;
            w.len    = last ? pred_len : '0;
            w.reason = last ? body_reason : hcbd_pkg::REASON_ZERO_SIZE;
            expected_words.push_back(w);
            due_cnt++;
            if (out_hit)
                payload_words++;
            if (last) begin
                // rearm for the next body
                reason_hits[int'(body_reason)]++;
                bodies++;
                dec_phase   = hcbd_pkg::PH_SIZE;
                size_acc    = '0;
                pred_len    = '0;
                body_reason = hcbd_pkg::REASON_RAN_OUT;
            end
        end
    endtask

    // Stimulus building
    task automatic put(input logic [7:0] b, input logic last);
        body_items.push_back('{data: b, last: last, drain: drain_next});
        drain_next = 1'b0;
    endtask

    function automatic logic [7:0] hex_char(input int unsigned d, input bit upper);
        if (d < 10)
            return 8'(int'("0") + d);
        return 8'((upper ? int'("A") : int'("a")) + d - 10);
    endfunction

    function automatic logic [7:0] text_byte();
        return 8'($urandom_range(32, 126));
    endfunction

    task automatic add_size_line(input int unsigned sz);
        bit started;
        bit upper;
        int unsigned nib;
        started = 1'b0;
        upper   = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 5) == 0)
            body_bytes.push_back("0");
        for (int s = 28; s >= 0; s -= 4) begin
            nib = (sz >> s) & 4'hF;
            if (nib != 0 || started || s == 0) begin
                started = 1'b1;
                body_bytes.push_back(hex_char(nib, upper));
            end
        end
        case ($urandom_range(0, 7))
            0: body_bytes.push_back(hcbd_pkg::CH_CR);
            1, 2: body_bytes.push_back(hcbd_pkg::CH_LF);
            3:
            begin
                body_bytes.push_back(hcbd_pkg::CH_SEMI);
                repeat ($urandom_range(0, 4)) body_bytes.push_back(text_byte());
                if ($urandom_range(0, 1))
                    body_bytes.push_back(hcbd_pkg::CH_CR);
                body_bytes.push_back(hcbd_pkg::CH_LF);
            end
            default:
            begin
                body_bytes.push_back(hcbd_pkg::CH_CR);
                body_bytes.push_back(hcbd_pkg::CH_LF);
            end
        endcase
    endtask

    task automatic add_random_body();
        int kind;
        int sz;
        logic [7:0] b;
        body_bytes.delete();
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            // raw noise, any byte value
            repeat ($urandom_range(1, 8)) body_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else begin
            repeat ($urandom_range(0, 4)) begin
                sz = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(1, 12);
                add_size_line(sz);
                repeat (sz) body_bytes.push_back(8'($urandom_range(0, 255)));
                case ($urandom_range(0, 5))
                    0: body_bytes.push_back(hcbd_pkg::CH_CR);
                    1: body_bytes.push_back(hcbd_pkg::CH_LF);
                    2: ;
                    default:
                    begin
                        body_bytes.push_back(hcbd_pkg::CH_CR);
                        body_bytes.push_back(hcbd_pkg::CH_LF);
                    end
                endcase
            end
            if (kind == 1) begin
                do
                    b = 8'($urandom_range(0, 255));
                while (nibble_of(b) >= 0 || b == hcbd_pkg::CH_CR || b == hcbd_pkg::CH_LF ||
                       b == hcbd_pkg::CH_SEMI);
                body_bytes.push_back(b);
                repeat ($urandom_range(0, 3)) body_bytes.push_back(8'($urandom_range(0, 255)));
            end
            else if (kind == 2) begin
                // stop mid-line or mid-chunk
                if (body_bytes.size() > 1)
                    repeat ($urandom_range(0, body_bytes.size() / 2)) void'(body_bytes.pop_back());
            end
            else begin
                body_bytes.push_back("0");
                case ($urandom_range(0, 3))
                    0: body_bytes.push_back(hcbd_pkg::CH_LF);
                    1: body_bytes.push_back(hcbd_pkg::CH_SEMI);
                    default: body_bytes.push_back(hcbd_pkg::CH_CR);
                endcase
                if ($urandom_range(0, 2) != 0) begin
                    body_bytes.push_back(hcbd_pkg::CH_LF);
                    body_bytes.push_back(hcbd_pkg::CH_CR);
                    body_bytes.push_back(hcbd_pkg::CH_LF);
                end
                repeat ($urandom_range(0, 2)) body_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        if (body_bytes.size() == 0)
            body_bytes.push_back(8'($urandom_range(0, 255)));
        foreach (body_bytes[i])
            put(body_bytes[i], i == body_bytes.size() - 1);
        random_items += body_bytes.size();
    endtask

    // Driver: present one word at a time, hold it while stalled
    body_item_t item;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            in_byte   <= 8'd0;
            last_byte <= 1'b0;
            gap_left  = 0;
        end
        else begin
            if (in_valid && !in_stall) begin
                predict_byte(in_byte, last_byte);
                fed_cnt <= fed_cnt + 1;
            end
            if (!in_valid || !in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (body_items.size() == 0)
                    in_valid <= 1'b0;
                else if (body_items[0].drain && fed_cnt < calm_from && got_cnt != due_cnt)
                    in_valid <= 1'b0;
                else if (fed_cnt < calm_from && $urandom_range(0, 9) == 0) begin
                    gap_left = $urandom_range(0, 9);
                    in_valid <= 1'b0;
                end
                else begin
                    item = body_items.pop_front();
                    in_valid  <= 1'b1;
                    in_byte   <= item.data;
                    last_byte <= item.last;
                end
            end
        end
    end

    // Receiver stall: random bursts, plus one long hold-off to back up the input
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end
        else begin
            if (!hold_done && fed_cnt >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (fed_cnt < calm_from && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 9);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Monitor: compare each taken word with the oldest prediction
    decoded_word_t want;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            got_cnt <= 0;
        else if (out_valid && !out_stall) begin
            got_cnt <= got_cnt + 1;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("word %0d: arrived with nothing predicted (byte %02h end %0b)",
                             got_cnt, data_byte, body_end);
            end
            else begin
                want = expected_words.pop_front();
                if (want.data !== data_byte || want.valid !== data_valid ||
                    want.last !== body_end || want.len !== decoded_length ||
                    want.reason !== end_reason) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("word %0d: expected byte %02h valid %0b end %0b len %0d reason %0d",
                                 got_cnt, want.data, want.valid, want.last, want.len,
                                 want.reason);
                        $display("word %0d: got      byte %02h valid %0b end %0b len %0d reason %0d",
                                 got_cnt, data_byte, data_valid, body_end,
                                 decoded_length, end_reason);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > cycle_limit) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_cnt, due_cnt - got_cnt);
            $display("http_chunked_body_decoder test failed");
            $finish;
        end
    end

    initial begin
        // Directed: CR then payload, trailer running into the next size line,
        // bare LF, empty size at ';', bytes ignored after stop
        put("1", 1'b0); put(hcbd_pkg::CH_CR, 1'b0); put(8'hFF, 1'b0);
        put("2", 1'b0); put(hcbd_pkg::CH_LF, 1'b0); put(8'h00, 1'b0); put(8'h80, 1'b0);
        put(hcbd_pkg::CH_CR, 1'b0); put(hcbd_pkg::CH_LF, 1'b0);
        put(hcbd_pkg::CH_SEMI, 1'b0); put(8'h55, 1'b1);
        // oversized size saturates, body runs out mid-chunk
        repeat (7) put("F", 1'b0);
        put("a", 1'b0); put(hcbd_pkg::CH_LF, 1'b0); put(8'h7F, 1'b0); put(8'h01, 1'b1);
        // invalid size character as the only byte
        put("@", 1'b1);
        // extension, payload, then a bad character where the next size starts
        put("1", 1'b0); put(hcbd_pkg::CH_SEMI, 1'b0); put(hcbd_pkg::CH_LF, 1'b0);
        put("q", 1'b0); put("G", 1'b1);

        drain_next = 1'b1;
        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
                drain_next = 1'b1;
            add_random_body();
        end

        // Last stretch and a closing body go with no idling on either side
        calm_from = body_items.size() - CALM_TAIL;
        put("3", 1'b0); put(hcbd_pkg::CH_CR, 1'b0); put(hcbd_pkg::CH_LF, 1'b0);
        repeat (3) put(8'($urandom_range(0, 255)), 1'b0);
        put(hcbd_pkg::CH_CR, 1'b0); put(hcbd_pkg::CH_LF, 1'b0); put("0", 1'b0);
        put(hcbd_pkg::CH_CR, 1'b0); put(hcbd_pkg::CH_LF, 1'b0);
        put(hcbd_pkg::CH_CR, 1'b0); put(hcbd_pkg::CH_LF, 1'b1);

        cycle_limit = longint'(body_items.size()) * 40 + 20000;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (body_items.size() != 0 || in_valid || got_cnt != due_cnt)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (expected_words.size() != 0) begin
            $display("%0d predicted words never arrived", expected_words.size());
            mismatches += expected_words.size();
        end

        $display("covered %0d bytes in %0d bodies, %0d payload words, %0d words checked",
                 fed_cnt, bodies, payload_words, got_cnt);
        $display("bodies ended by zero size %0d, bad size char %0d, input ran out %0d",
                 reason_hits[int'(hcbd_pkg::REASON_ZERO_SIZE)],
                 reason_hits[int'(hcbd_pkg::REASON_BAD_CHAR)],
                 reason_hits[int'(hcbd_pkg::REASON_RAN_OUT)]);
        if (mismatches == 0)
            $display("http_chunked_body_decoder test passed");
        else
            $display("http_chunked_body_decoder test failed");
        $finish;
    end

endmodule
